// File: src/hpr_pkg.sv
// Package for the hashed perceptron reuse predictor: sizes, payload types, ALU codes.
package hpr_pkg;

    localparam int WEIGHT_ROWS   = 256;
    localparam int HISTORY_DEPTH = 4;
    localparam int NUM_FEATURES  = 6;
    localparam int MAX_ROUNDS    = 64;

    localparam int ADDR_W        = 32;
    localparam int HIST_W        = 20;
    localparam int IDX_W         = $clog2(WEIGHT_ROWS);
    localparam int HIST_PTR_W    = $clog2(HISTORY_DEPTH);
    localparam int FEAT_W        = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int ROUND_CNT_W   = $clog2(MAX_ROUNDS + 1);

    localparam int WEIGHT_W      = 16;
    localparam int RATE_W        = 8;
    localparam int SUM_W         = 19;
    localparam int ROUNDS_W      = 7;
    localparam int PROD_W        = WEIGHT_W + RATE_W;

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_LEARN_RATE = 1'b1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_INIT    = 16'd128;
    localparam logic [SUM_W-1:0]    THRESHOLD_INIT = 19'd512;
    localparam logic [RATE_W-1:0]   RATE_INIT      = 8'd26;

    typedef logic [HIST_W-1:0]                       hist_t;
    typedef logic [IDX_W-1:0]                        idx_t;
    typedef logic [NUM_FEATURES-1:0][IDX_W-1:0]      idx_vec_t;
    typedef logic [WEIGHT_W-1:0]                     weight_t;
    typedef logic [NUM_FEATURES-1:0][WEIGHT_W-1:0]   weight_vec_t;
    typedef logic [SUM_W-1:0]                        sum_t;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address;
        logic              reuse_outcome;
    } in_t;

    typedef struct packed {
        logic                predicted_reuse;
        logic [SUM_W-1:0]    weight_sum;
        logic [ROUNDS_W-1:0] train_rounds;
        logic                round_limit_hit;
    } out_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_DEC = 2'd1,
        ALU_INC = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [RATE_W-1:0] rate;
    } alu_req_t;

endpackage

// File: src/hpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/hpr_history.sv
// Address history ring and shift/XOR hashing into per-table indexes.
module hpr_history (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hpr_pkg::hist_t   push_addr,
    output hpr_pkg::idx_vec_t idx
);
    import hpr_pkg::*;

    hist_t                 hist_reg [HISTORY_DEPTH];
    logic [HIST_PTR_W-1:0] tail_reg;
    logic [HIST_PTR_W-1:0] tail_next;
    hist_t                 h [4];
    hist_t                 f;

    always_comb
    begin
        if (tail_reg == HIST_PTR_W'(HISTORY_DEPTH - 1))
        begin
            tail_next = '0;
        end
        else
        begin
            tail_next = tail_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            tail_reg            <= tail_next;
            hist_reg[tail_next] <= push_addr;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (tail_reg >= HIST_PTR_W'(i))
            begin
                h[i] = hist_reg[tail_reg - HIST_PTR_W'(i)];
            end
            else
            begin
                h[i] = hist_reg[tail_reg + HIST_PTR_W'(HISTORY_DEPTH - i)];
            end
        end
    end

    always_comb
    begin
        f   = '0;
        idx = '0;
        for (int k = 0; k < NUM_FEATURES; k++)
        begin
            case (k)
                0:       f = (h[0] >> 2) ^ h[0];
                1:       f = (h[1] >> 1) ^ h[0];
                2:       f = (h[2] >> 2) ^ h[0];
                3:       f = (h[3] >> 3) ^ h[0];
                4:       f = (h[0] >> 4) ^ h[0];
                default: f = (h[0] >> 7) ^ h[0];
            endcase
            idx[k] = f[IDX_W-1:0];
        end
    end

endmodule

// File: src/hpr_alu.sv
// Shared arithmetic unit: accumulate a weight or scale it down or up by the learning rate.
module hpr_alu (
    input  hpr_pkg::alu_req_t req,
    input  hpr_pkg::weight_t  w,
    input  hpr_pkg::sum_t     acc,
    output hpr_pkg::weight_t  w_new,
    output hpr_pkg::sum_t     acc_new
);
    import hpr_pkg::*;

    logic [PROD_W-1:0]   prod;
    weight_t             delta;
    weight_t             step;
    logic [WEIGHT_W:0]   inc_sum;

    assign prod    = PROD_W'(w) * PROD_W'(req.rate);
    assign delta   = prod[PROD_W-1:RATE_W];
    assign step    = (delta == '0) ? WEIGHT_W'(1) : delta;
    assign inc_sum = {1'b0, w} + {1'b0, step};

    always_comb
    begin
        w_new   = w;
        acc_new = acc;
        unique case (req.op)
            ALU_ADD: acc_new = acc + SUM_W'(w);
            ALU_DEC: w_new   = w - delta;
            ALU_INC: w_new   = inc_sum[WEIGHT_W] ? '1 : inc_sum[WEIGHT_W-1:0];
            default: w_new   = w;
        endcase
    end

endmodule

// File: src/hashed_perceptron_reuse_predictor_unit.sv
// Top level of the hashed perceptron reuse predictor: sequencer, weight tables, config port.
// Steps: index, load, sum the tables, check, write back, strobe done; each training round
// updates every table and sums again, then checks; one shared ALU step per cycle.
// Throughput: one item at a time; start is taken again in the cycle done strobes.
// Reset: clears history and control registers, then sweeps all WEIGHT_ROWS (256) rows of
// the tables to 0.5 with busy high; config writes are taken during the sweep.
module hashed_perceptron_reuse_predictor_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  hpr_pkg::in_t                      cmd,
    output logic                              done,
    output hpr_pkg::out_t                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hpr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [hpr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [hpr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import hpr_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_INDEX  = 8'b0000_0100,
        S_LOAD   = 8'b0000_1000,
        S_SUM    = 8'b0001_0000,
        S_CHECK  = 8'b0010_0000,
        S_UPDATE = 8'b0100_0000,
        S_WRITE  = 8'b1000_0000
    } state_t;

    state_t                 state_reg,     state_next;
    logic [IDX_W-1:0]       clr_reg,       clr_next;
    logic [FEAT_W-1:0]      feat_reg,      feat_next;
    sum_t                   acc_reg,       acc_next;
    sum_t                   sum_reg,       sum_next;
    sum_t                   init_reg,      init_next;
    logic                   first_reg,     first_next;
    logic [ROUND_CNT_W-1:0] rounds_reg,    rounds_next;
    logic                   limit_reg,     limit_next;
    logic                   op_reg,        op_next;
    logic                   outcome_reg,   outcome_next;
    idx_vec_t               idx_reg,       idx_next;
    weight_vec_t            w_reg,         w_next;
    logic                   done_reg,      done_next;
    out_t                   result_reg,    result_next;
    sum_t                   threshold_reg;
    logic [RATE_W-1:0]      learn_rate_reg;

    logic                   push;
    idx_vec_t               hash_idx;
    alu_req_t               alu_req;
    weight_t                alu_w_new;
    sum_t                   alu_acc_new;
    logic                   ram_we;
    idx_vec_t               ram_waddr;
    weight_vec_t            ram_wdata;
    weight_vec_t            ram_rdata;
    logic                   wrong;
    logic                   cfg_write;
    logic                   cfg_sel;

    assign busy   = (state_reg != S_IDLE);
    assign push   = start && (state_reg == S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;

    hpr_history u_history (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_addr (cmd.address[HIST_W-1:0]),
        .idx       (hash_idx)
    );

    hpr_alu u_alu (
        .req     (alu_req),
        .w       (w_reg[feat_reg]),
        .acc     (acc_reg),
        .w_new   (alu_w_new),
        .acc_new (alu_acc_new)
    );

    for (genvar g = 0; g < NUM_FEATURES; g++)
    begin : g_table
        hpr_ram #(
            .WIDTH (WEIGHT_W),
            .DEPTH (WEIGHT_ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr[g]),
            .wdata (ram_wdata[g]),
            .raddr (hash_idx[g]),
            .rdata (ram_rdata[g])
        );
    end

    // configuration port
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[APB_ADDR_W-1];

    always_comb
    begin
        unique case (cfg_sel)
            REG_THRESHOLD:  prdata = APB_DATA_W'(threshold_reg);
            REG_LEARN_RATE: prdata = APB_DATA_W'(learn_rate_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_INIT;
            learn_rate_reg <= RATE_INIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_THRESHOLD:  threshold_reg  <= pwdata[SUM_W-1:0];
                REG_LEARN_RATE: learn_rate_reg <= pwdata[RATE_W-1:0];
                default:        threshold_reg  <= threshold_reg;
            endcase
        end
    end

    assign wrong = outcome_reg ? (sum_reg > threshold_reg) : (sum_reg <= threshold_reg);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        feat_next    = feat_reg;
        acc_next     = acc_reg;
        sum_next     = sum_reg;
        init_next    = init_reg;
        first_next   = first_reg;
        rounds_next  = rounds_reg;
        limit_next   = limit_reg;
        op_next      = op_reg;
        outcome_next = outcome_reg;
        idx_next     = idx_reg;
        w_next       = w_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        alu_req.op   = ALU_ADD;
        alu_req.rate = learn_rate_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = w_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                for (int i = 0; i < NUM_FEATURES; i++)
                begin
                    ram_waddr[i] = clr_reg;
                    ram_wdata[i] = WEIGHT_INIT;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(WEIGHT_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = cmd.opcode;
                    outcome_next = cmd.reuse_outcome;
                    state_next   = S_INDEX;
                end
            end
            S_INDEX:
            begin
                idx_next   = hash_idx;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                w_next      = ram_rdata;
                feat_next   = '0;
                acc_next    = '0;
                first_next  = 1'b1;
                rounds_next = '0;
                limit_next  = 1'b0;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                alu_req.op = ALU_ADD;
                acc_next   = alu_acc_new;
                if (feat_reg == FEAT_W'(NUM_FEATURES - 1))
                begin
                    sum_next = alu_acc_new;
                    if (first_reg)
                    begin
                        init_next = alu_acc_new;
                    end
                    first_next = 1'b0;
                    state_next = S_CHECK;
                end
                else
                begin
                    feat_next = feat_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                if (op_reg && wrong)
                begin
                    if (rounds_reg == ROUND_CNT_W'(MAX_ROUNDS))
                    begin
                        limit_next = 1'b1;
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        feat_next  = '0;
                        state_next = S_UPDATE;
                    end
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_UPDATE:
            begin
                alu_req.op         = outcome_reg ? ALU_DEC : ALU_INC;
                w_next[feat_reg]   = alu_w_new;
                if (feat_reg == FEAT_W'(NUM_FEATURES - 1))
                begin
                    rounds_next = rounds_reg + 1'b1;
                    feat_next   = '0;
                    acc_next    = '0;
                    state_next  = S_SUM;
                end
                else
                begin
                    feat_next = feat_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                ram_we                       = 1'b1;
                done_next                    = 1'b1;
                result_next.predicted_reuse  = (init_reg <= threshold_reg);
                result_next.weight_sum       = init_reg;
                result_next.train_rounds     = ROUNDS_W'(rounds_reg);
                result_next.round_limit_hit  = limit_reg;
                state_next                   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            feat_reg    <= '0;
            first_reg   <= 1'b0;
            rounds_reg  <= '0;
            limit_reg   <= 1'b0;
            op_reg      <= 1'b0;
            outcome_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            feat_reg    <= feat_next;
            first_reg   <= first_next;
            rounds_reg  <= rounds_next;
            limit_reg   <= limit_next;
            op_reg      <= op_next;
            outcome_reg <= outcome_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sum_reg    <= sum_next;
        init_reg   <= init_next;
        idx_reg    <= idx_next;
        w_reg      <= w_next;
        result_reg <= result_next;
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_WRITE))
        else $error("done without write-back");

    a_round_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rounds_reg <= ROUND_CNT_W'(MAX_ROUNDS))
        else $error("training rounds above cap");

    a_limit_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.round_limit_hit |-> result.train_rounds == ROUNDS_W'(MAX_ROUNDS))
        else $error("round limit flagged below cap");

endmodule

// File: tb/sv/hashed_perceptron_reuse_predictor_unit_test.sv
// Self-checking testbench for the hashed perceptron reuse predictor unit.
module hashed_perceptron_reuse_predictor_unit_test;

    import hpr_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD  = {REG_THRESHOLD, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_LEARN_RATE = {REG_LEARN_RATE, 2'b00};
    localparam logic                  OP_PREDICT      = 1'b0;
    localparam logic                  OP_TRAIN        = 1'b1;
    localparam int unsigned           WEIGHT_CEIL     = (1 << WEIGHT_W) - 1;
    localparam int unsigned           THRESHOLD_TOP   = 393210;
    localparam int                    RAND_ITEMS      = 1330;
    localparam int                    RAND_PHASES     = 6;
    localparam int                    POOL_SIZE       = 16;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    in_t                   cmd;
    logic                  done;
    out_t                  result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hist_t                 hist_ring [HISTORY_DEPTH];
    logic [HIST_PTR_W-1:0] hist_head;
    weight_t               weights [NUM_FEATURES][WEIGHT_ROWS];
    sum_t                  threshold_cfg;
    logic [RATE_W-1:0]     rate_cfg;

    in_t                   access_queue [$];
    out_t                  predictions [$];
    in_t                   cur_item;
    bit                    presenting;
    bit                    taken;
    bit                    quiet;
    bit                    calm;
    int                    gap_left;
    int                    items_queued;
    int                    results_seen;
    int                    errors;
    int                    n_train;
    int                    n_capped;
    int                    n_rounds;
    int                    n_reuse;

    hashed_perceptron_reuse_predictor_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned weight_total(input idx_vec_t ix);
        int unsigned s;
        s = 0;
        for (int i = 0; i < NUM_FEATURES; i++)
            s += weights[i][ix[i]];
        return s;
    endfunction

    function automatic out_t model_access(input in_t c);
        hist_t       h [4];
        idx_vec_t    ix;
        int unsigned s;
        int unsigned first;
        int unsigned w;
        int unsigned d;
        int unsigned rounds;
        logic        capped;
        out_t        r;
        hist_head = hist_head + 1'b1;
        hist_ring[hist_head] = c.address[HIST_W-1:0];
        for (int i = 0; i < 4; i++)
            h[i] = hist_ring[HIST_PTR_W'(hist_head - i)];
        ix[0] = idx_t'((h[0] >> 2) ^ h[0]);
        ix[1] = idx_t'((h[1] >> 1) ^ h[0]);
        ix[2] = idx_t'((h[2] >> 2) ^ h[0]);
        ix[3] = idx_t'((h[3] >> 3) ^ h[0]);
        ix[4] = idx_t'((h[0] >> 4) ^ h[0]);
        ix[5] = idx_t'((h[0] >> 7) ^ h[0]);
        s = weight_total(ix);
        first = s;
        rounds = 0;
        capped = 1'b0;
        if (c.opcode == OP_TRAIN)
        begin
            while (c.reuse_outcome ? (s > threshold_cfg) : (s <= threshold_cfg))
            begin
                if (rounds >= MAX_ROUNDS)
                begin
                    capped = 1'b1;
                    break;
                end
                for (int i = 0; i < NUM_FEATURES; i++)
                begin
                    w = weights[i][ix[i]];
                    d = (w * rate_cfg) >> RATE_W;
                    if (c.reuse_outcome)
                        w = w - d;
                    else
                    begin
                        if (d == 0)
                            d = 1;
                        w = w + d;
                        if (w > WEIGHT_CEIL)
                            w = WEIGHT_CEIL;
                    end
                    weights[i][ix[i]] = weight_t'(w);
                end
                rounds++;
                s = weight_total(ix);
            end
        end
        r.predicted_reuse = (first <= threshold_cfg);
        r.weight_sum      = sum_t'(first);
        r.train_rounds    = ROUNDS_W'(rounds);
        r.round_limit_hit = capped;
        return r;
    endfunction

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                if (predictions.size() == 0)
                begin
                    $error("result with no item outstanding: %p", result);
                    errors++;
                end
                else
                begin
                    want = predictions.pop_front();
                    if (result.predicted_reuse !== want.predicted_reuse)
                    begin
                        $error("predicted_reuse: expected %0d, got %0d",
                               want.predicted_reuse, result.predicted_reuse);
                        errors++;
                    end
                    if (result.weight_sum !== want.weight_sum)
                    begin
                        $error("weight_sum: expected %0d, got %0d",
                               want.weight_sum, result.weight_sum);
                        errors++;
                    end
                    if (result.train_rounds !== want.train_rounds)
                    begin
                        $error("train_rounds: expected %0d, got %0d",
                               want.train_rounds, result.train_rounds);
                        errors++;
                    end
                    if (result.round_limit_hit !== want.round_limit_hit)
                    begin
                        $error("round_limit_hit: expected %0d, got %0d",
                               want.round_limit_hit, result.round_limit_hit);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = model_access(cmd);
                predictions.push_back(want);
                taken = 1'b1;
                if (cmd.opcode == OP_TRAIN)
                    n_train++;
                n_rounds += want.train_rounds;
                n_capped += want.round_limit_hit;
                n_reuse  += want.predicted_reuse;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            presenting = 1'b0;
            taken = 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (taken)
            begin
                taken = 1'b0;
                presenting = 1'b0;
            end
            if (!presenting && access_queue.size() > 0)
            begin
                cur_item = access_queue.pop_front();
                presenting = 1'b1;
                if ($urandom_range(0, 39) == 0)
                    calm = !calm;
            end
            if (gap_left > 0)
                gap_left--;
            else if (!quiet && !calm && $urandom_range(0, 7) == 0)
                gap_left = $urandom_range(1, 6);
            start <= presenting && gap_left == 0;
            cmd   <= cur_item;
        end
    end

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input int unsigned value);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        if (addr == ADDR_THRESHOLD)
            word[SUM_W-1:0] = value[SUM_W-1:0];
        else
            word[RATE_W-1:0] = value[RATE_W-1:0];
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_THRESHOLD)
            threshold_cfg = word[SUM_W-1:0];
        else
            rate_cfg = word[RATE_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_access(input logic op, input logic [ADDR_W-1:0] addr,
                                input logic outcome);
        in_t c;
        c.opcode        = op;
        c.address       = addr;
        c.reuse_outcome = outcome;
        access_queue.push_back(c);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (access_queue.size() > 0 || presenting || results_seen != items_queued)
            @(negedge clk);
    endtask

    initial
    begin
        logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
        logic              pool_reuse [POOL_SIZE];
        int                slot [4];
        int                budget;
        int                k;
        int                reps;
        logic [ADDR_W-1:0] a;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cur_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet = 1'b0;
        calm = 1'b0;
        items_queued = 0;
        results_seen = 0;
        errors = 0;
        n_train = 0;
        n_capped = 0;
        n_rounds = 0;
        n_reuse = 0;
        hist_head = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            hist_ring[i] = '0;
        for (int i = 0; i < NUM_FEATURES; i++)
            for (int j = 0; j < WEIGHT_ROWS; j++)
                weights[i][j] = WEIGHT_INIT;
        threshold_cfg = THRESHOLD_INIT;
        rate_cfg = RATE_INIT;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            addr_pool[i] = $urandom();
            pool_reuse[i] = 1'($urandom_range(0, 1));
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(ADDR_THRESHOLD, 512);
        write_reg(ADDR_LEARN_RATE, 26);
        queue_access(OP_PREDICT, 32'h0000_0000, 1'b1);
        queue_access(OP_PREDICT, 32'hFFFF_FFFF, 1'b0);
        queue_access(OP_TRAIN,   32'h0000_0000, 1'b1);
        queue_access(OP_TRAIN,   32'h0000_0000, 1'b0);
        queue_access(OP_TRAIN,   32'hFFF0_0000, 1'b1);
        queue_access(OP_TRAIN,   32'h000F_FFFF, 1'b0);
        queue_access(OP_TRAIN,   32'h1234_5678, 1'b1);
        queue_access(OP_TRAIN,   32'h1234_5678, 1'b1);
        queue_access(OP_PREDICT, 32'hAAAA_AAAA, 1'b1);
        queue_access(OP_PREDICT, 32'h5555_5555, 1'b0);
        wait_drained();

        write_reg(ADDR_THRESHOLD, 0);
        write_reg(ADDR_LEARN_RATE, 255);
        queue_access(OP_TRAIN, 32'h0000_0000, 1'b1);
        queue_access(OP_TRAIN, 32'h0000_0000, 1'b0);
        queue_access(OP_TRAIN, 32'h8BAD_F00D, 1'b1);
        wait_drained();

        write_reg(ADDR_THRESHOLD, THRESHOLD_TOP);
        repeat (3)
            queue_access(OP_PREDICT, 32'h000C_AFE0, 1'b0);
        queue_access(OP_TRAIN,   32'h000C_AFE0, 1'b0);
        queue_access(OP_PREDICT, 32'h000C_AFE0, 1'b0);
        queue_access(OP_TRAIN,   32'h000C_AFE0, 1'b1);
        wait_drained();

        write_reg(ADDR_THRESHOLD, 1000);
        write_reg(ADDR_LEARN_RATE, 0);
        repeat (3)
            queue_access(OP_PREDICT, 32'h7654_3210, 1'b0);
        queue_access(OP_TRAIN, 32'h7654_3210, 1'b0);
        queue_access(OP_TRAIN, 32'h7654_3210, 1'b1);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            quiet = (p == RAND_PHASES - 1);
            write_reg(ADDR_THRESHOLD, $urandom_range(256, 1600));
            write_reg(ADDR_LEARN_RATE, (p == 1) ? 1 : (p == 2) ? 255 : $urandom_range(2, 254));
            budget = RAND_ITEMS / RAND_PHASES;
            while (budget > 0)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    k = $urandom_range(1, 4);
                    reps = $urandom_range(2, 6);
                    for (int j = 0; j < k; j++)
                        slot[j] = $urandom_range(0, POOL_SIZE - 1);
                    for (int r = 0; r < reps; r++)
                        for (int j = 0; j < k; j++)
                            queue_access(($urandom_range(0, 4) != 0) ? OP_TRAIN : OP_PREDICT,
                                         addr_pool[slot[j]],
                                         pool_reuse[slot[j]] ^ ($urandom_range(0, 7) == 0));
                    budget -= k * reps;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        a = $urandom();
                        addr_pool[slot[0]] = a;
                        pool_reuse[slot[0]] = a[0];
                    end
                end
                else
                begin
                    queue_access(1'($urandom_range(0, 1)), $urandom(),
                                 1'($urandom_range(0, 1)));
                    budget--;
                end
            end
            wait_drained();
        end

        repeat (30) @(negedge clk);
        if (predictions.size() != 0)
        begin
            $error("%0d results never arrived", predictions.size());
            errors++;
        end
        $display("Covered %0d accesses (%0d trained, %0d training rounds, %0d at the round cap,",
                 results_seen, n_train, n_rounds, n_capped);
        $display("%0d predicted reuse) over threshold and learn rate extremes and 6 random settings",
                 n_reuse);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
